@@ src/dwra_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual wave row animator package
// Shared types, register indexes and wave constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dwra_pkg;

    // Hidden entries at each end of a wave store.
    localparam int WAVE_LEN = 5;

    typedef logic [2:0] level_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [1:0] CFG_FWD_HOLDOFF  = 2'd1;
    localparam logic [1:0] CFG_REV_HOLDOFF  = 2'd2;

    localparam logic [15:0] FRAME_PERIOD_RST = 16'd200;
    localparam logic [15:0] FWD_HOLDOFF_RST  = 16'd1000;
    localparam logic [15:0] REV_HOLDOFF_RST  = 16'd100;

    // Forward levels from entry 0 upward.
    localparam level_t FWD_PATTERN [WAVE_LEN] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
    // Reverse levels from the last entry downward.
    localparam level_t REV_PATTERN [WAVE_LEN] = '{3'd5, 3'd2, 3'd3, 3'd4, 3'd5};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME,
        ST_FWD,
        ST_REV,
        ST_EMIT,
        ST_SPIN
    } state_t;

    typedef enum logic [1:0] {
        GAP_FRAME,
        GAP_FWD,
        GAP_REV
    } gap_sel_t;

    typedef struct packed {
        gap_sel_t gap_sel;
        logic     frame_hit;
        logic     fwd_hit;
        logic     rev_hit;
        logic     rotate;
    } seq_ctrl_t;

endpackage

`default_nettype wire

@@ src/dual_wave_row_animator.sv @@
// ----------------------------------------------------------------------------
// Dual wave row animator
// Millisecond tick in, per-row forward and reverse wave levels out.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one request per millisecond tick: the time and two
// motion sensor levels. When a frame is due, the block advances both waves,
// injects new waves for sensors past their holdoff, and sends ROWS results
// on the m_ channel, row 0 first, with m_last_row set on the final row.
// A tick that starts no frame produces no result.
// Timing: after the request is taken the block passes the frame, forward and
// reverse checks before the first row is valid; each further row follows in the
// cycle after the previous one is taken. After the last row the stores keep
// rotating until a full turn brings them back to their home position; a tick
// without a frame returns to idle after the frame check. The stores rotate
// once per cycle, while not stalled, to bring each row to the readout tap.
// When m_ready is low the current row holds and the stores wait.
// Configuration is a separate cfg_ channel that is always ready; indexes
// 0, 1 and 2 select frame period, forward holdoff and reverse holdoff.
// Reset clears both wave stores and all timers and restores the defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wave_row_animator #(
    parameter int ROWS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_now_ms,
    input  wire logic        s_sensor_a,
    input  wire logic        s_sensor_b,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_row_index,
    output logic [2:0]       m_forward_level,
    output logic [2:0]       m_reverse_level,
    output logic             m_last_row,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int DEPTH = ROWS + 2 * dwra_pkg::WAVE_LEN;
    localparam int CW    = $clog2(DEPTH);

    logic [15:0] frame_period_reg;
    logic [15:0] fwd_holdoff_reg;
    logic [15:0] rev_holdoff_reg;
    logic [31:0] now_reg;
    logic        sensor_a_reg;
    logic        sensor_b_reg;
    logic [31:0] last_frame_reg;
    logic [31:0] last_fwd_reg;
    logic [31:0] last_rev_reg;

    logic                exceeds;
    logic [CW-1:0]       cnt;
    dwra_pkg::seq_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_period_reg <= dwra_pkg::FRAME_PERIOD_RST;
            fwd_holdoff_reg  <= dwra_pkg::FWD_HOLDOFF_RST;
            rev_holdoff_reg  <= dwra_pkg::REV_HOLDOFF_RST;
        end else if (cfg_valid) begin
            if (cfg_index == dwra_pkg::CFG_FRAME_PERIOD) frame_period_reg <= cfg_data;
            if (cfg_index == dwra_pkg::CFG_FWD_HOLDOFF)  fwd_holdoff_reg  <= cfg_data;
            if (cfg_index == dwra_pkg::CFG_REV_HOLDOFF)  rev_holdoff_reg  <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg      <= s_now_ms;
            sensor_a_reg <= s_sensor_a;
            sensor_b_reg <= s_sensor_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_frame_reg <= '0;
            last_fwd_reg   <= '0;
            last_rev_reg   <= '0;
        end else begin
            if (ctrl.frame_hit) last_frame_reg <= now_reg;
            if (ctrl.fwd_hit)   last_fwd_reg   <= now_reg;
            if (ctrl.rev_hit)   last_rev_reg   <= now_reg;
        end
    end

    dwra_gap_unit u_gap (
        .now_ms       (now_reg),
        .last_frame   (last_frame_reg),
        .last_fwd     (last_fwd_reg),
        .last_rev     (last_rev_reg),
        .frame_period (frame_period_reg),
        .fwd_holdoff  (fwd_holdoff_reg),
        .rev_holdoff  (rev_holdoff_reg),
        .sel          (ctrl.gap_sel),
        .exceeds      (exceeds)
    );

    dwra_seq #(
        .ROWS  (ROWS),
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .m_ready  (m_ready),
        .exceeds  (exceeds),
        .sensor_a (sensor_a_reg),
        .sensor_b (sensor_b_reg),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .cnt      (cnt),
        .ctrl     (ctrl)
    );

    dwra_fwd_store #(
        .DEPTH (DEPTH)
    ) u_fwd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .tap     (m_forward_level)
    );

    dwra_rev_store #(
        .DEPTH (DEPTH)
    ) u_rev (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .tap     (m_reverse_level)
    );

    assign m_row_index = 6'(cnt);
    assign m_last_row  = cnt == CW'(ROWS - 1);

    // The block never takes a new tick while rows are still going out.
    a_busy_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a row is pending");

    // A taken tick always takes the block out of the idle state in the next cycle.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after a tick was taken");

    // The final row ends the burst of results.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_row |=> !m_valid)
        else $error("row sent after the last row");

    // Rows advance by one after each taken result within a frame.
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |=>
            m_valid && m_row_index == $past(m_row_index) + 6'd1)
        else $error("row index did not advance by one");

endmodule

`default_nettype wire

@@ src/dwra_gap_unit.sv @@
// ----------------------------------------------------------------------------
// Elapsed time compare unit
// Shared subtract and compare: (now - last) > limit, modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module dwra_gap_unit (
    input  wire logic [31:0]       now_ms,
    input  wire logic [31:0]       last_frame,
    input  wire logic [31:0]       last_fwd,
    input  wire logic [31:0]       last_rev,
    input  wire logic [15:0]       frame_period,
    input  wire logic [15:0]       fwd_holdoff,
    input  wire logic [15:0]       rev_holdoff,
    input  wire dwra_pkg::gap_sel_t sel,
    output logic                   exceeds
);

    logic [31:0] last_sel;
    logic [15:0] limit_sel;
    logic [31:0] elapsed;

    always_comb begin
        case (sel)
            dwra_pkg::GAP_FRAME: begin
                last_sel  = last_frame;
                limit_sel = frame_period;
            end
            dwra_pkg::GAP_FWD: begin
                last_sel  = last_fwd;
                limit_sel = fwd_holdoff;
            end
            dwra_pkg::GAP_REV: begin
                last_sel  = last_rev;
                limit_sel = rev_holdoff;
            end
            default: begin
                last_sel  = last_frame;
                limit_sel = frame_period;
            end
        endcase
    end

    assign elapsed = now_ms - last_sel;
    assign exceeds = elapsed > {16'd0, limit_sel};

endmodule

`default_nettype wire

@@ src/dwra_fwd_store.sv @@
// ----------------------------------------------------------------------------
// Forward wave store
// Shift line that moves up at each frame and rotates down for readout.
// ----------------------------------------------------------------------------
`default_nettype none

module dwra_fwd_store #(
    parameter int DEPTH = 26
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dwra_pkg::seq_ctrl_t ctrl,
    output dwra_pkg::level_t         tap
);

    dwra_pkg::level_t wave_reg  [DEPTH];
    dwra_pkg::level_t wave_next [DEPTH];

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            wave_next[k] = wave_reg[k];
        end
        if (ctrl.frame_hit) begin
            for (int k = 1; k < DEPTH; k++) begin
                wave_next[k] = wave_reg[k-1];
            end
            wave_next[0] = '0;
        end else if (ctrl.fwd_hit) begin
            for (int k = 0; k < dwra_pkg::WAVE_LEN; k++) begin
                wave_next[k] = dwra_pkg::FWD_PATTERN[k];
            end
        end else if (ctrl.rotate) begin
            // Circular rotation toward entry 0; a full turn restores the store.
            for (int k = 0; k < DEPTH - 1; k++) begin
                wave_next[k] = wave_reg[k+1];
            end
            wave_next[DEPTH-1] = wave_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                wave_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                wave_reg[k] <= wave_next[k];
            end
        end
    end

    assign tap = wave_reg[dwra_pkg::WAVE_LEN];

endmodule

`default_nettype wire

@@ src/dwra_rev_store.sv @@
// ----------------------------------------------------------------------------
// Reverse wave store
// Shift line that moves down at each frame and rotates down for readout.
// ----------------------------------------------------------------------------
`default_nettype none

module dwra_rev_store #(
    parameter int DEPTH = 26
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dwra_pkg::seq_ctrl_t ctrl,
    output dwra_pkg::level_t         tap
);

    dwra_pkg::level_t wave_reg  [DEPTH];
    dwra_pkg::level_t wave_next [DEPTH];

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            wave_next[k] = wave_reg[k];
        end
        if (ctrl.frame_hit) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                wave_next[k] = wave_reg[k+1];
            end
            wave_next[DEPTH-1] = '0;
        end else if (ctrl.rev_hit) begin
            for (int k = 0; k < dwra_pkg::WAVE_LEN; k++) begin
                wave_next[DEPTH-1-k] = dwra_pkg::REV_PATTERN[k];
            end
        end else if (ctrl.rotate) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                wave_next[k] = wave_reg[k+1];
            end
            wave_next[DEPTH-1] = wave_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                wave_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                wave_reg[k] <= wave_next[k];
            end
        end
    end

    assign tap = wave_reg[dwra_pkg::WAVE_LEN];

endmodule

`default_nettype wire

@@ src/dwra_seq.sv @@
// ----------------------------------------------------------------------------
// Frame sequencer
// Steps one request through the three time checks, row output and store turn.
// ----------------------------------------------------------------------------
`default_nettype none

module dwra_seq #(
    parameter int ROWS  = 16,
    parameter int DEPTH = 26,
    parameter int CW    = 5
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                m_ready,
    input  wire logic                exceeds,
    input  wire logic                sensor_a,
    input  wire logic                sensor_b,
    output logic                     s_ready,
    output logic                     m_valid,
    output logic [CW-1:0]            cnt,
    output dwra_pkg::seq_ctrl_t      ctrl
);

    dwra_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             row_end;
    logic             turn_end;

    assign row_end  = cnt_reg == CW'(ROWS - 1);
    assign turn_end = cnt_reg == CW'(DEPTH - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dwra_pkg::ST_IDLE: begin
                if (s_valid) state_next = dwra_pkg::ST_FRAME;
            end
            dwra_pkg::ST_FRAME: begin
                state_next = exceeds ? dwra_pkg::ST_FWD : dwra_pkg::ST_IDLE;
            end
            dwra_pkg::ST_FWD: begin
                state_next = dwra_pkg::ST_REV;
            end
            dwra_pkg::ST_REV: begin
                state_next = dwra_pkg::ST_EMIT;
            end
            dwra_pkg::ST_EMIT: begin
                if (m_ready && row_end) state_next = dwra_pkg::ST_SPIN;
            end
            dwra_pkg::ST_SPIN: begin
                if (turn_end) state_next = dwra_pkg::ST_IDLE;
            end
            default: begin
                state_next = dwra_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl         = '0;
        ctrl.gap_sel = dwra_pkg::GAP_FRAME;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            dwra_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            dwra_pkg::ST_FRAME: begin
                ctrl.frame_hit = exceeds;
            end
            dwra_pkg::ST_FWD: begin
                ctrl.gap_sel = dwra_pkg::GAP_FWD;
                ctrl.fwd_hit = sensor_a && exceeds;
            end
            dwra_pkg::ST_REV: begin
                ctrl.gap_sel = dwra_pkg::GAP_REV;
                ctrl.rev_hit = sensor_b && exceeds;
            end
            dwra_pkg::ST_EMIT: begin
                m_valid     = 1'b1;
                ctrl.rotate = m_ready;
            end
            dwra_pkg::ST_SPIN: begin
                ctrl.rotate = 1'b1;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // The counter follows every rotation, so it wraps when the stores are back home.
    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.rotate) begin
            cnt_next = turn_end ? '0 : cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dwra_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

`default_nettype wire
